/* hdl/sbm_pkg.sv */
`default_nettype none
package sbm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BAR_COUNT  = 3'd0;
  localparam logic [2:0] REG_ATTACK     = 3'd1;
  localparam logic [2:0] REG_RELEASE    = 3'd2;
  localparam logic [2:0] REG_PEAK_FALL  = 3'd3;
  localparam logic [2:0] REG_FLOOR_DB   = 3'd4;

  localparam logic [6:0]  RST_BAR_COUNT = 7'd32;
  localparam logic [15:0] RST_ATTACK    = 16'd36045;
  localparam logic [15:0] RST_RELEASE   = 16'd210;
  localparam logic [15:0] RST_PEAK_FALL = 16'd56;
  localparam logic [6:0]  RST_FLOOR_DB  = 7'd62;

  localparam logic [9:0]  DT_CAP        = 10'd250;
  localparam logic [18:0] TEN_LOG10_2   = 19'd197283;  // 10*log10(2) in Q16
  localparam int          QDEPTH        = 4;

  localparam logic OP_BIN   = 1'b0;
  localparam logic OP_DECAY = 1'b1;

  typedef struct packed {
    logic [6:0]  n;        // bars in use, already clamped
    logic [6:0]  fl;       // floor in dB, zero taken as one
    logic [15:0] attack;
    logic [15:0] rel;
    logic [15:0] pfall;
  } cfg_t;

  typedef struct packed {
    logic        decay;
    logic [5:0]  bar;
    logic [63:0] sq;
    logic [7:0]  dt;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE, B_START, B_NORM, B_LOG, B_SCALE, B_ABS, B_DIV1, B_CLAMP, B_DIV2,
    B_TILT, B_SAT, B_READ, B_BALL1, B_BALL2, B_DREAD, B_DECAY, B_PEAK, B_EMIT
  } bstate_t;

  // Subtract d from v, but never go below lo.
  function automatic logic [15:0] sub_floor(input logic [15:0] v, input logic [23:0] d,
                                            input logic [15:0] lo);
    logic [23:0] diff;
    diff = {8'd0, v} - d;
    if ({8'd0, v} < d || diff[15:0] < lo) begin
      return lo;
    end
    return diff[15:0];
  endfunction

  // Log2 in Q16, used at elaboration for the reference level.
  function automatic logic [31:0] log2_q16(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] s;
    logic [31:0] r;
    int n;
    if (x == 64'd0) begin
      return 32'd0;
    end
    n = 63;
    while (!x[n]) begin
      n = n - 1;
    end
    if (n >= 31) begin
      m = x >> (n - 31);
    end else begin
      m = x << (31 - n);
    end
    r = 32'(n) << 16;
    for (int i = 15; i >= 0; i--) begin
      s = m * m;
      if (s[63]) begin
        r[i] = 1'b1;
        m = s >> 32;
      end else begin
        m = s >> 31;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/spectrum_bar_meter_ballistics.sv */
`default_nettype none
// Spectrum bar meter with attack/release ballistics and a falling peak hold.
// FFT bins enter through a queue-like push/full port at up to one transfer
// per cycle while full is low; a front section squares each bin and keeps
// the band maximum, and every decay tick and every band end on a stored bar
// becomes a job in a four-entry queue. A back section runs each job: a band
// end goes through six normalize steps and sixteen squaring steps for the
// logarithm, two 24-step restoring divisions for the dB scaling and the
// tilt, then the read, ballistics and write of the bar's entry; a band of
// zero energy skips to the read. A decay tick does a read-modify-write of
// the level/peak memory for each bar in use. Results leave through an output
// register read by empty/pop; the back section waits while that register
// holds an untaken result. Bar state resets at once through per-bar valid
// bits, so there is no clearing pass after reset. Configuration is written
// through wr_en/wr_index/wr_data by the user only while idle; not enforced.
module spectrum_bar_meter_ballistics #(
  parameter int FFT_SIZE = 1024,
  parameter int MAX_BARS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode,
  input  wire logic [5:0]         bar,
  input  wire logic signed [31:0] bin_real,
  input  wire logic signed [31:0] bin_imag,
  input  wire logic               band_end,
  input  wire logic [9:0]         dt_ms,
  output logic                    empty,
  input  wire logic               pop,
  output logic [5:0]              bar_index,
  output logic [15:0]             level,
  output logic [15:0]             peak_hold,
  output logic                    last,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [15:0]        wr_data
);
  import sbm_pkg::*;

  // Bars that fit in both the storage and one decay transfer burst.
  localparam int BAR_CAP = (MAX_BARS < 64) ? MAX_BARS : 64;

  logic [6:0]  bar_count;
  logic [15:0] attack_gain;
  logic [15:0] release_per_ms;
  logic [15:0] peak_fall_per_ms;
  logic [6:0]  floor_db;

  cfg_t cfg;
  job_t f_job;
  job_t q_head;
  logic f_push;
  logic q_empty;
  logic q_afull;
  logic q_pop;

  // Registers are plain writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_count        <= RST_BAR_COUNT;
      attack_gain      <= RST_ATTACK;
      release_per_ms   <= RST_RELEASE;
      peak_fall_per_ms <= RST_PEAK_FALL;
      floor_db         <= RST_FLOOR_DB;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BAR_COUNT: bar_count        <= wr_data[6:0];
        REG_ATTACK:    attack_gain      <= wr_data;
        REG_RELEASE:   release_per_ms   <= wr_data;
        REG_PEAK_FALL: peak_fall_per_ms <= wr_data;
        REG_FLOOR_DB:  floor_db         <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  // The bar count is clamped to at least one and at most the storage size,
  // and a zero floor counts as one decibel.
  always_comb begin
    if (bar_count == 7'd0) begin
      cfg.n = 7'd1;
    end else if (bar_count > 7'(BAR_CAP)) begin
      cfg.n = 7'(BAR_CAP);
    end else begin
      cfg.n = bar_count;
    end
    cfg.fl     = (floor_db == 7'd0) ? 7'd1 : floor_db;
    cfg.attack = attack_gain;
    cfg.rel    = release_per_ms;
    cfg.pfall  = peak_fall_per_ms;
  end

  sbm_front #(.MAX_BARS(MAX_BARS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .opcode        (opcode),
    .bar           (bar),
    .bin_real      (bin_real),
    .bin_imag      (bin_imag),
    .band_end      (band_end),
    .dt_ms         (dt_ms),
    .q_almost_full (q_afull),
    .full          (full),
    .q_push        (f_push),
    .q_job         (f_job)
  );

  sbm_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (f_push),
    .push_job    (f_job),
    .pop         (q_pop),
    .head        (q_head),
    .empty       (q_empty),
    .almost_full (q_afull)
  );

  sbm_back #(.FFT_SIZE(FFT_SIZE), .MAX_BARS(MAX_BARS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .bar_index (bar_index),
    .level     (level),
    .peak_hold (peak_hold),
    .last      (last)
  );
endmodule
`default_nettype wire

/* hdl/sbm_ram.sv */
`default_nettype none
module sbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                           wdata,
  output logic      [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/sbm_queue.sv */
`default_nettype none
module sbm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sbm_pkg::job_t push_job,
  input  wire logic          pop,
  output sbm_pkg::job_t      head,
  output logic               empty,
  output logic               almost_full
);
  import sbm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t              slots [QDEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [PW:0]       count;

  assign head        = slots[rptr];
  assign empty       = (count == '0);
  // One item may still sit in the front's square stage, so keep a spare slot.
  assign almost_full = (count > (PW + 1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* hdl/sbm_front.sv */
`default_nettype none
module sbm_front #(
  parameter int MAX_BARS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               opcode,
  input  wire logic [5:0]         bar,
  input  wire logic signed [31:0] bin_real,
  input  wire logic signed [31:0] bin_imag,
  input  wire logic               band_end,
  input  wire logic [9:0]         dt_ms,
  input  wire logic               q_almost_full,
  output logic                    full,
  output logic                    q_push,
  output sbm_pkg::job_t           q_job
);
  import sbm_pkg::*;

  logic        s1_valid;
  logic        s1_op;
  logic [5:0]  s1_bar;
  logic        s1_end;
  logic [7:0]  s1_dt;
  logic [63:0] s1_re2;
  logic [63:0] s1_im2;
  logic [63:0] band_max;

  logic [31:0] ar;
  logic [31:0] ai;
  logic [63:0] sq;
  logic [63:0] mx;
  logic        in_range;

  assign full = q_almost_full;

  // Two's complement negate also gives 2^31 for the most negative value.
  assign ar = bin_real[31] ? (~bin_real + 32'd1) : bin_real;
  assign ai = bin_imag[31] ? (~bin_imag + 32'd1) : bin_imag;

  assign sq       = s1_re2 + s1_im2;
  assign mx       = (sq > band_max) ? sq : band_max;
  assign in_range = (32'(s1_bar) < MAX_BARS);

  always_comb begin
    q_push       = 1'b0;
    q_job.decay  = (s1_op == OP_DECAY);
    q_job.bar    = s1_bar;
    q_job.sq     = mx;
    q_job.dt     = s1_dt;
    if (s1_valid) begin
      if (s1_op == OP_DECAY) begin
        q_push = 1'b1;
      end else if (s1_end && in_range) begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_op  <= opcode;
    s1_bar <= bar;
    s1_end <= band_end;
    s1_dt  <= (dt_ms > DT_CAP) ? DT_CAP[7:0] : dt_ms[7:0];
    s1_re2 <= 64'(ar) * 64'(ar);
    s1_im2 <= 64'(ai) * 64'(ai);
    if (rst) begin
      s1_valid <= 1'b0;
      band_max <= '0;
    end else begin
      s1_valid <= push && !full;
      if (s1_valid && s1_op == OP_BIN) begin
        band_max <= s1_end ? 64'd0 : mx;
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/sbm_back.sv */
`default_nettype none
module sbm_back #(
  parameter int FFT_SIZE = 1024,
  parameter int MAX_BARS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sbm_pkg::cfg_t cfg,
  input  wire logic          q_empty,
  input  wire sbm_pkg::job_t q_head,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [5:0]         bar_index,
  output logic [15:0]        level,
  output logic [15:0]        peak_hold,
  output logic               last
);
  import sbm_pkg::*;

  localparam int          AW    = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam logic [63:0] REFSQ = 64'(FFT_SIZE) * 64'(FFT_SIZE) * 64'd4096;
  localparam logic [31:0] LREF  = log2_q16(REFSQ);

  bstate_t state, state_next;

  job_t               job;
  logic [63:0]        x;
  logic [5:0]         lz;
  logic [4:0]         cnt;
  logic [31:0]        m;
  logic [15:0]        frac;
  logic signed [42:0] p;
  logic               neg;
  logic [23:0]        dvd;
  logic [6:0]         rem;
  logic [6:0]         dvs;
  logic [15:0]        v;
  logic [37:0]        tprod;
  logic [15:0]        t;
  logic [15:0]        lv;
  logic [15:0]        pk;
  logic               up;
  logic [31:0]        amul;
  logic [23:0]        rel_dt;
  logic [23:0]        pk_dt;
  logic [5:0]         idx;
  logic               out_valid;

  logic [MAX_BARS-1:0] vld;
  logic                rvld;
  logic [AW-1:0]       addr;
  logic                ram_we;
  logic [31:0]         rdata;
  logic                slot_free;
  logic                dec_last;

  logic [63:0]        msq;
  logic signed [23:0] d;
  logic [42:0]        pabs;
  logic [7:0]         trial;
  logic               ge;
  logic [15:0]        rlv;
  logic [15:0]        rpk;

  assign msq   = 64'(m) * 64'(m);
  assign d     = $signed({2'b00, 6'(63 - 32'(lz)), frac}) - $signed({2'b00, LREF[21:0]});
  assign pabs  = p[42] ? 43'(-p) : 43'(p);
  assign trial = {rem, dvd[23]};
  assign ge    = (trial >= {1'b0, dvs});
  assign rlv   = rvld ? rdata[15:0] : 16'd0;
  assign rpk   = rvld ? rdata[31:16] : 16'd0;

  assign slot_free = !out_valid || pop;
  assign dec_last  = ({1'b0, idx} == cfg.n - 7'd1);
  assign empty     = !out_valid;

  sbm_ram #(.WIDTH(32), .DEPTH(MAX_BARS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata ({pk, lv}),
    .rdata (rdata)
  );

  always_comb begin
    q_pop  = (state == B_IDLE) && !q_empty;
    ram_we = (state == B_EMIT) && slot_free;
    addr   = job.decay ? AW'(idx) : AW'(job.bar);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_START;
      B_START: begin
        if (job.decay) begin
          state_next = B_DREAD;
        end else if (job.sq == 64'd0) begin
          state_next = B_READ;
        end else begin
          state_next = B_NORM;
        end
      end
      B_NORM:  if (cnt == 5'd0) state_next = B_LOG;
      B_LOG:   if (cnt == 5'd0) state_next = B_SCALE;
      B_SCALE: state_next = B_ABS;
      B_ABS:   state_next = B_DIV1;
      B_DIV1:  if (cnt == 5'd0) state_next = B_CLAMP;
      B_CLAMP: state_next = B_DIV2;
      B_DIV2:  if (cnt == 5'd0) state_next = B_TILT;
      B_TILT:  state_next = B_SAT;
      B_SAT:   state_next = B_READ;
      B_READ:  state_next = B_BALL1;
      B_BALL1: state_next = B_BALL2;
      B_BALL2: state_next = B_PEAK;
      B_DREAD: state_next = B_DECAY;
      B_DECAY: state_next = B_PEAK;
      B_PEAK:  state_next = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          state_next = (job.decay && !dec_last) ? B_DREAD : B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rvld <= vld[addr];
    unique case (state)
      B_IDLE: begin
        job <= q_head;
        idx <= '0;
        t   <= '0;
      end
      B_START: begin
        rel_dt <= cfg.rel * job.dt;
        pk_dt  <= cfg.pfall * job.dt;
        x      <= job.sq;
        lz     <= '0;
        cnt    <= 5'd5;
      end
      B_NORM: begin
        unique case (cnt[2:0])
          3'd5: if (x[63:32] == '0) begin x <= x << 32; lz <= lz + 6'd32; end
          3'd4: if (x[63:48] == '0) begin x <= x << 16; lz <= lz + 6'd16; end
          3'd3: if (x[63:56] == '0) begin x <= x << 8;  lz <= lz + 6'd8;  end
          3'd2: if (x[63:60] == '0) begin x <= x << 4;  lz <= lz + 6'd4;  end
          3'd1: if (x[63:62] == '0) begin x <= x << 2;  lz <= lz + 6'd2;  end
          default: if (!x[63]) begin x <= x << 1; lz <= lz + 6'd1; end
        endcase
        cnt <= (cnt == 5'd0) ? 5'd15 : cnt - 5'd1;
      end
      B_LOG:   cnt <= cnt - 5'd1;
      B_SCALE: p <= 43'(d) * 43'($signed({1'b0, TEN_LOG10_2}));
      B_ABS: begin
        neg <= p[42];
        dvd <= pabs[39:16];
        rem <= '0;
        dvs <= cfg.fl;
        cnt <= 5'd23;
      end
      B_DIV1, B_DIV2: begin
        rem <= ge ? 7'(trial - {1'b0, dvs}) : trial[6:0];
        dvd <= {dvd[22:0], ge};
        cnt <= cnt - 5'd1;
      end
      B_CLAMP: begin
        if (neg && dvd != '0) begin
          v <= (dvd >= 24'd65536) ? 16'd0 : 16'(24'd65536 - dvd);
        end else begin
          v <= 16'hFFFF;
        end
        dvd <= {3'd0, job.bar, 15'd0};
        rem <= '0;
        dvs <= cfg.n;
        cnt <= 5'd23;
      end
      B_TILT:  tprod <= 38'(v) * 38'(22'd65536 + 22'(dvd));
      B_SAT:   t <= (tprod[37:16] > 22'd65535) ? 16'hFFFF : tprod[31:16];
      B_READ:  ;
      B_BALL1: begin
        lv   <= rlv;
        pk   <= rpk;
        up   <= (t > rlv);
        amul <= 32'(16'(t - rlv)) * 32'(cfg.attack);
      end
      B_BALL2: lv <= up ? 16'(lv + amul[31:16]) : sub_floor(lv, rel_dt, t);
      B_DREAD: ;
      B_DECAY: begin
        lv <= sub_floor(rlv, rel_dt, 16'd0);
        pk <= rpk;
      end
      B_PEAK:  pk <= (lv > pk) ? lv : sub_floor(pk, pk_dt, lv);
      B_EMIT:  if (slot_free && job.decay) idx <= idx + 6'd1;
      default: ;
    endcase
    // The mantissa squaring loop runs alongside the state case above.
    if (state == B_NORM) begin
      unique case (cnt[2:0])
        3'd0: m <= x[63] ? x[63:32] : x[62:31];
        default: ;
      endcase
    end
    if (state == B_LOG) begin
      m    <= msq[63] ? msq[63:32] : msq[62:31];
      frac <= {frac[14:0], msq[63]};
    end
    if (state == B_EMIT && slot_free) begin
      bar_index <= job.decay ? idx : job.bar;
      level     <= lv;
      peak_hold <= pk;
      last      <= !job.decay || dec_last;
    end
    if (rst) begin
      state     <= B_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vld[addr] <= 1'b1;
      end
      if (state == B_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* tb/ballistics_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Watches the bin and result channels, predicts every bar result and
// compares each popped result with the oldest prediction.
module ballistics_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               full,
  input  wire logic               opcode,
  input  wire logic [5:0]         bar,
  input  wire logic signed [31:0] bin_real,
  input  wire logic signed [31:0] bin_imag,
  input  wire logic               band_end,
  input  wire logic [9:0]         dt_ms,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire logic [5:0]         bar_index,
  input  wire logic [15:0]        level,
  input  wire logic [15:0]        peak_hold,
  input  wire logic               last,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [15:0]        wr_data,
  output int                      failures,
  output int                      pending,
  output int                      checked
);
  import sbm_pkg::*;

  typedef struct {
    logic [5:0]  bar_index;
    logic [15:0] level;
    logic [15:0] peak_hold;
    logic        last;
  } bar_result_t;

  bar_result_t expected_bars[$];

  logic [6:0]  bar_count_r;
  logic [15:0] attack_r;
  logic [15:0] release_r;
  logic [15:0] peak_fall_r;
  logic [6:0]  floor_r;
  logic [63:0] band_peak_sq;
  logic [15:0] meter_level[64];
  logic [15:0] meter_peak[64];

  function automatic logic [31:0] log2_fixed(input logic [63:0] x);
    int          msb;
    logic [63:0] mant;
    logic [63:0] prod;
    logic [31:0] acc;
    if (x == 64'd0) return 32'd0;
    msb = 0;
    for (int k = 0; k < 64; k++) if (x[k]) msb = k;
    mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    acc = 32'(msb) << 16;
    for (int k = 15; k >= 0; k--) begin
      prod = mant * mant;
      if (prod[63]) begin
        acc[k] = 1'b1;
        mant = prod >> 32;
      end else begin
        mant = prod >> 31;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] drop_to(input logic [15:0] v, input longint d,
                                          input logic [15:0] lo);
    if (longint'(v) < d || longint'(v) - d < longint'(lo)) return lo;
    return 16'(longint'(v) - d);
  endfunction

  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? (64'd0 - {{32{1'b1}}, v}) : {32'd0, v};
  endfunction

  function automatic int active_bars();
    if (bar_count_r < 7'd1) return 1;
    if (bar_count_r > 7'd64) return 64;
    return int'(bar_count_r);
  endfunction

  // Level target of one band: dB below full scale, windowed by the floor,
  // then tilted up toward the high bars.
  function automatic longint band_target(input logic [63:0] sq, input int b, input int n);
    longint dlog;
    longint q;
    longint v;
    longint t;
    longint fl;
    if (sq == 64'd0) return 0;
    fl = (floor_r == 7'd0) ? 1 : longint'(floor_r);
    dlog = longint'(log2_fixed(sq)) - (longint'(32) << 16);
    q = (dlog * 197283) / (fl * 65536);
    v = 65536 + q;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    t = (v * (65536 + (32768 * b) / n)) >> 16;
    return (t > 65535) ? 65535 : t;
  endfunction

  task automatic settle_peak(input int b, input longint dt);
    if (meter_level[b] > meter_peak[b]) meter_peak[b] = meter_level[b];
    else meter_peak[b] = drop_to(meter_peak[b], longint'(peak_fall_r) * dt, meter_level[b]);
  endtask

  task automatic log_result(input int b, input logic is_last);
    bar_result_t r;
    r.bar_index = 6'(b);
    r.level     = meter_level[b];
    r.peak_hold = meter_peak[b];
    r.last      = is_last;
    expected_bars.push_back(r);
  endtask

  task automatic advance_meter();
    int          n;
    longint      dt;
    longint      t;
    longint      lv;
    logic [63:0] sq;
    n  = active_bars();
    dt = (dt_ms > DT_CAP) ? longint'(DT_CAP) : longint'(dt_ms);
    if (opcode == OP_DECAY) begin
      for (int i = 0; i < n; i++) begin
        meter_level[i] = drop_to(meter_level[i], longint'(release_r) * dt, 16'd0);
        settle_peak(i, dt);
        log_result(i, i == n - 1);
      end
    end else begin
      sq = magnitude(bin_real) * magnitude(bin_real) + magnitude(bin_imag) * magnitude(bin_imag);
      if (sq > band_peak_sq) band_peak_sq = sq;
      if (band_end) begin
        t = band_target(band_peak_sq, int'(bar), n);
        band_peak_sq = 64'd0;
        lv = longint'(meter_level[bar]);
        if (t > lv) lv = lv + (((t - lv) * longint'(attack_r)) >> 16);
        else lv = longint'(drop_to(16'(lv), longint'(release_r) * dt, 16'(t)));
        meter_level[bar] = 16'(lv);
        settle_peak(int'(bar), dt);
        log_result(int'(bar), 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    failures++;
  endtask

  initial begin
    failures = 0;
    checked  = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    bar_result_t want;
    if (rst) begin
      bar_count_r  = RST_BAR_COUNT;
      attack_r     = RST_ATTACK;
      release_r    = RST_RELEASE;
      peak_fall_r  = RST_PEAK_FALL;
      floor_r      = RST_FLOOR_DB;
      band_peak_sq = 64'd0;
      for (int i = 0; i < 64; i++) begin
        meter_level[i] = 16'd0;
        meter_peak[i]  = 16'd0;
      end
      expected_bars.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BAR_COUNT: bar_count_r = wr_data[6:0];
          REG_ATTACK:    attack_r    = wr_data;
          REG_RELEASE:   release_r   = wr_data;
          REG_PEAK_FALL: peak_fall_r = wr_data;
          REG_FLOOR_DB:  floor_r     = wr_data[6:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_bars.size() == 0) begin
          report_mismatch($sformatf("unexpected result for bar %0d", bar_index));
        end else begin
          want = expected_bars.pop_front();
          checked++;
          if (bar_index !== want.bar_index)
            report_mismatch($sformatf("bar_index %0d, expected %0d", bar_index, want.bar_index));
          if (level !== want.level)
            report_mismatch($sformatf("bar %0d level %0d, expected %0d",
                                      want.bar_index, level, want.level));
          if (peak_hold !== want.peak_hold)
            report_mismatch($sformatf("bar %0d peak_hold %0d, expected %0d",
                                      want.bar_index, peak_hold, want.peak_hold));
          if (last !== want.last)
            report_mismatch($sformatf("bar %0d last %0b, expected %0b",
                                      want.bar_index, last, want.last));
        end
      end
      if (push && !full) advance_meter();
    end
    pending = expected_bars.size();
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stimulus and verdict for the spectrum bar meter. The checker beside the
// block does all prediction; this module only offers bins, decay ticks and
// register settings, and throttles the result side.
module testbench;
  import sbm_pkg::*;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic               opcode;
  logic [5:0]         bar;
  logic signed [31:0] bin_real;
  logic signed [31:0] bin_imag;
  logic               band_end;
  logic [9:0]         dt_ms;
  logic               empty;
  logic               pop;
  logic [5:0]         bar_index;
  logic [15:0]        level;
  logic [15:0]        peak_hold;
  logic               last;
  logic               wr_en;
  logic [2:0]         wr_index;
  logic [15:0]        wr_data;

  int failures;
  int pending;
  int checked;
  int items_sent;
  int ticks_sent;
  int hold_len;
  bit quiet;
  int bars_now;

  spectrum_bar_meter_ballistics uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode), .bar(bar),
    .bin_real(bin_real), .bin_imag(bin_imag), .band_end(band_end), .dt_ms(dt_ms),
    .empty(empty), .pop(pop), .bar_index(bar_index), .level(level),
    .peak_hold(peak_hold), .last(last), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  ballistics_checker meter_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode), .bar(bar),
    .bin_real(bin_real), .bin_imag(bin_imag), .band_end(band_end), .dt_ms(dt_ms),
    .empty(empty), .pop(pop), .bar_index(bar_index), .level(level),
    .peak_hold(peak_hold), .last(last), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data), .failures(failures), .pending(pending), .checked(checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. The slowest legal run (every item a 64-bar decay tick, each
  // result held off by the longest pop idle) stays well under a tenth of this.
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side. A long hold requested by the sender side is counted out
  // here; otherwise pop idles in random bursts until the quiet tail.
  initial begin
    pop = 1'b0;
    hold_len = 0;
    forever begin
      if (hold_len > 0) begin
        pop <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer happens. push is left high,
  // unless a random pause lowers it, so back-to-back items need no second
  // assignment in one step; any caller that then waits must lower it first.
  task automatic send_item(input logic op, input logic [5:0] b, input logic [31:0] re,
                           input logic [31:0] im, input logic be, input logic [9:0] dt);
    opcode   <= op;
    bar      <= b;
    bin_real <= re;
    bin_imag <= im;
    band_end <= be;
    dt_ms    <= dt;
    push     <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (op == OP_DECAY) ticks_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop offering and let every expected result arrive. Bins inside a band
  // produce nothing, so a short margin covers any work still in flight.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // All five registers are rewritten on each change of settings.
  task automatic apply_settings(input logic [6:0] n, input logic [15:0] atk,
                                input logic [15:0] rel, input logic [15:0] pf,
                                input logic [6:0] fl);
    logic [15:0] vals[5];
    vals = '{{9'd0, n}, atk, rel, pf, {9'd0, fl}};
    for (int i = 0; i < 5; i++) begin
      wr_en    <= 1'b1;
      wr_index <= 3'(i);
      wr_data  <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
    bars_now = (n == 7'd0) ? 1 : ((n > 7'd64) ? 64 : int'(n));
  endtask

  // Bin component with a wide spread of magnitudes, edges included.
  function automatic logic [31:0] random_component();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'd0;
      3: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [9:0] random_dt();
    return ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 60));
  endfunction

  // Mostly whole bands of one to four bins; some decay ticks and some
  // stray bins with random flags as noise.
  task automatic random_traffic(input int count);
    int          stop_at;
    int          nbins;
    logic [5:0]  b;
    logic [9:0]  dt;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 13))
        0: send_item(OP_DECAY, 6'($urandom), $urandom, $urandom, 1'($urandom), random_dt());
        1: send_item(OP_BIN, 6'($urandom), random_component(), random_component(),
                     1'($urandom), random_dt());
        default: begin
          nbins = $urandom_range(1, 4);
          b = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, bars_now - 1));
          dt = random_dt();
          for (int k = 0; k < nbins; k++)
            send_item(OP_BIN, b, random_component(), random_component(), k == nbins - 1, dt);
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    opcode = OP_BIN;
    bar = '0;
    bin_real = '0;
    bin_imag = '0;
    band_end = 1'b0;
    dt_ms = '0;
    wr_en = 1'b0;
    wr_index = REG_BAR_COUNT;
    wr_data = '0;
    items_sent = 0;
    ticks_sent = 0;
    quiet = 1'b0;
    bars_now = 32;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: the most negative bins, a band of
    // zero energy, a full-scale band, bins inside a band that only update
    // the maximum, a bar past the bars in use, and decay with long frames.
    send_item(OP_BIN, 6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 10'd0);
    send_item(OP_BIN, 6'd1, 32'd0, 32'd0, 1'b1, 10'd5);
    send_item(OP_BIN, 6'd2, 32'h0000_0100, 32'hffff_ff00, 1'b0, 10'd16);
    send_item(OP_BIN, 6'd2, 32'h7fff_ffff, 32'd1, 1'b0, 10'd16);
    send_item(OP_BIN, 6'd2, 32'hffff_ffff, 32'd0, 1'b1, 10'd16);
    send_item(OP_BIN, 6'd63, 32'h0100_0000, 32'h0040_0000, 1'b1, 10'd1023);
    send_item(OP_BIN, 6'd31, 32'd1, 32'd0, 1'b1, 10'd3);
    send_item(OP_DECAY, 6'd17, 32'h1234_5678, 32'h9abc_def0, 1'b1, 10'd251);
    send_item(OP_BIN, 6'd0, 32'd0, 32'd0, 1'b1, 10'd1);
    send_item(OP_DECAY, 6'd0, 32'd0, 32'd0, 1'b0, 10'd0);
    drain();

    // Degenerate settings: bar count and floor of zero act as one.
    apply_settings(7'd0, 16'hffff, 16'd0, 16'd0, 7'd0);
    send_item(OP_BIN, 6'd0, 32'h0000_8000, 32'd0, 1'b1, 10'd10);
    send_item(OP_BIN, 6'd5, 32'h4000_0000, 32'h4000_0000, 1'b1, 10'd10);
    send_item(OP_DECAY, 6'd0, 32'd0, 32'd0, 1'b0, 10'd1023);
    drain();

    // Upper extremes: bar count above the maximum, all rates at full scale.
    apply_settings(7'd127, 16'hffff, 16'hffff, 16'hffff, 7'd127);
    send_item(OP_BIN, 6'd40, 32'h0010_0000, 32'h0001_0000, 1'b1, 10'd0);
    send_item(OP_DECAY, 6'd0, 32'd0, 32'd0, 1'b0, 10'd1);
    send_item(OP_BIN, 6'd40, 32'h0000_0010, 32'd0, 1'b1, 10'd250);
    drain();

    apply_settings(7'd1, 16'd0, 16'd1, 16'd1, 7'd1);
    random_traffic(70);

    // Sender pauses until every expected result is in.
    drain();
    apply_settings(7'd64, 16'd40000, 16'd300, 16'd20, 7'd120);
    random_traffic(40);

    // Long receiver stall while band ends keep coming, so the job queue
    // and the output register fill and full holds the sender back.
    hold_len = 600;
    for (int k = 0; k < 14; k++)
      send_item(OP_BIN, 6'(k), random_component(), random_component(), 1'b1, 10'd7);
    random_traffic(30);
    drain();

    apply_settings(7'd12, 16'($urandom), 16'($urandom_range(0, 2000)),
                   16'($urandom_range(0, 500)), 7'($urandom_range(1, 120)));
    random_traffic(70);
    drain();

    // Final stretch without idling on either side.
    apply_settings(7'd32, RST_ATTACK, RST_RELEASE, RST_PEAK_FALL, RST_FLOOR_DB);
    quiet = 1'b1;
    random_traffic(60);
    drain();
    repeat (400) @(posedge clk);

    $display("Run covered %0d items (%0d decay ticks) and %0d checked bar results,",
             items_sent, ticks_sent, checked);
    $display("across bar counts 0..127, floors 0..127 and rate extremes.");
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hdl/sbm_pkg.sv
hdl/sbm_ram.sv
hdl/sbm_queue.sv
hdl/sbm_front.sv
hdl/sbm_back.sv
hdl/spectrum_bar_meter_ballistics.sv
tb/ballistics_checker.sv
tb/testbench.sv
